### rtl/assert_macros.svh
// assertion helpers included by utf8_stream_decoder
// each check is sampled on clk and switched off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every sampled edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/utf8_pkg.sv
// ----------------------------------------------------------------------------
// utf8_pkg
// Shared types and constants for the six-byte UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package utf8_pkg;

    localparam int CP_W    = 31;
    localparam int COUNT_W = 3;
    localparam int BYTE_W  = 8;

    // result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_TRUNC   = 2'd2
    } status_t;

    // one decoded result
    typedef struct packed {
        logic [CP_W-1:0]    code_point;
        logic [COUNT_W-1:0] byte_count;
        status_t            status;
    } result_t;

endpackage

### rtl/utf8_stream_decoder.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Streaming decoder for the original six-byte UTF-8 form.
// Input channel: one text byte per request (in_byte, end_of_text) under
// in_valid / in_ready. Output channel: code_point, byte_count and status under
// out_valid / out_ready; a result appears when a sequence completes, when a
// byte cannot lead a sequence (status invalid) or when end_of_text cuts a
// sequence short (status truncated). Continuation bytes are not checked.
// Throughput is one byte per cycle while in_ready is high: the lead decode and the six-bit shift
// into the partial value sit between the input ports and a result register.
// A finished result is registered in the result register, or in the skid register on a stall.
// A two-entry output buffer (result register plus skid register) holds one
// further result while the receiver stalls; bytes that finish nothing keep
// flowing, and in_ready drops only when both entries hold results.
// Reset (rst_n low, asynchronous) closes any open sequence and empties the
// output buffer.
// ----------------------------------------------------------------------------
module utf8_stream_decoder
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [utf8_pkg::BYTE_W-1:0]    in_byte,
    input  logic                           end_of_text,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [utf8_pkg::CP_W-1:0]      code_point,
    output logic [utf8_pkg::COUNT_W-1:0]   byte_count,
    output logic [1:0]                     status
);

`include "assert_macros.svh"

    // sequence state
    logic [utf8_pkg::CP_W-1:0]    partial_reg, partial_next;
    logic [utf8_pkg::COUNT_W-1:0] left_reg, left_next;
    logic [utf8_pkg::COUNT_W-1:0] len_reg, len_next;

    // output buffer
    logic              out_valid_reg, skid_valid_reg;
    utf8_pkg::result_t out_reg, skid_reg;

    utf8_pkg::result_t res;
    logic              res_valid;
    logic              in_take, out_take;
    logic [utf8_pkg::COUNT_W-1:0] left_dec;
    logic [utf8_pkg::CP_W-1:0]    shifted;

    assign in_ready = !skid_valid_reg;
    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid_reg && out_ready;

    assign left_dec = left_reg - 3'd1;
    assign shifted  = {partial_reg[utf8_pkg::CP_W-7:0], in_byte[5:0]};

    // lead decode and continuation step
    always_comb
    begin
        partial_next = partial_reg;
        left_next    = left_reg;
        len_next     = len_reg;
        res_valid    = 1'b0;
        res          = '{code_point: '0, byte_count: '0, status: utf8_pkg::ST_OK};

        if (left_reg == '0)
        begin
            partial_next = '0;
            len_next     = '0;
            unique case (in_byte) inside
                [8'h00:8'h7f]:
                begin
                    res_valid      = 1'b1;
                    res.code_point = {24'd0, in_byte[6:0]};
                    res.byte_count = 3'd1;
                end
                [8'hc0:8'hdf]:
                begin
                    partial_next = {26'd0, in_byte[4:0]};
                    len_next     = 3'd2;
                end
                [8'he0:8'hef]:
                begin
                    partial_next = {27'd0, in_byte[3:0]};
                    len_next     = 3'd3;
                end
                [8'hf0:8'hf7]:
                begin
                    partial_next = {28'd0, in_byte[2:0]};
                    len_next     = 3'd4;
                end
                [8'hf8:8'hfb]:
                begin
                    partial_next = {29'd0, in_byte[1:0]};
                    len_next     = 3'd5;
                end
                [8'hfc:8'hfd]:
                begin
                    partial_next = {30'd0, in_byte[0]};
                    len_next     = 3'd6;
                end
                default:
                begin
                    res_valid  = 1'b1;
                    res.status = utf8_pkg::ST_INVALID;
                end
            endcase

            // a multi-byte lead opens a sequence unless the text ends here
            if (len_next != '0)
            begin
                if (end_of_text)
                begin
                    res_valid    = 1'b1;
                    res.status   = utf8_pkg::ST_TRUNC;
                    partial_next = '0;
                    len_next     = '0;
                end
                else
                begin
                    left_next = len_next - 3'd1;
                end
            end
        end
        else
        begin
            // later byte: shift in six payload bits
            if (left_dec == '0)
            begin
                res_valid      = 1'b1;
                res.code_point = shifted;
                res.byte_count = len_reg;
                partial_next   = '0;
                left_next      = '0;
                len_next       = '0;
            end
            else if (end_of_text)
            begin
                res_valid    = 1'b1;
                res.status   = utf8_pkg::ST_TRUNC;
                partial_next = '0;
                left_next    = '0;
                len_next     = '0;
            end
            else
            begin
                partial_next = shifted;
                left_next    = left_dec;
            end
        end
    end

    // sequence state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
            left_reg    <= '0;
            len_reg     <= '0;
        end
        else if (in_take)
        begin
            partial_reg <= partial_next;
            left_reg    <= left_next;
            len_reg     <= len_next;
        end
    end

    // output buffer occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_take && res_valid)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            out_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output buffer payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_take && res_valid)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign code_point = out_reg.code_point;
    assign byte_count = out_reg.byte_count;
    assign status     = out_reg.status;

    // terms for the checks
    logic out_err, out_ok, out_blank, count_fine, seq_fine;
    assign out_err    = out_valid_reg && (out_reg.status != utf8_pkg::ST_OK);
    assign out_ok     = out_valid_reg && (out_reg.status == utf8_pkg::ST_OK);
    assign out_blank  = (out_reg.code_point == '0) && (out_reg.byte_count == '0);
    assign count_fine = (out_reg.byte_count != '0) && (out_reg.byte_count <= 3'd6);
    assign seq_fine   = ((left_reg == '0) == (len_reg == '0))
                        && (left_reg < len_reg || len_reg == '0);

    // checks
    `ASSERT_IMPLIES(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full with output empty")
    `ASSERT_IMPLIES(a_err_zero, out_err, out_blank, "error result carries data")
    `ASSERT_IMPLIES(a_ok_count, out_ok, count_fine, "ok result with bad byte count")
    `ASSERT_ALWAYS(a_seq_state, seq_fine, "open sequence state inconsistent")

endmodule
